/* design/kasumi_pkg.sv */
// Shared types, S-box tables and round functions for the KASUMI cipher pipeline.
// No dependencies; used by kasumi_round and kasumi_block_cipher.
package kasumi_pkg;

  localparam int ROUNDS = 8;
  localparam int CELL_STAGES = 3;
  localparam int LATENCY = ROUNDS * CELL_STAGES;

  // configuration register indexes (64-bit registers, 8-byte stride)
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [31:0] x;
    logic [31:0] y;
  } blk_t;

  typedef struct packed {
    logic [15:0] kl1;
    logic [15:0] kl2;
    logic [15:0] ko1;
    logic [15:0] ko2;
    logic [15:0] ko3;
    logic [15:0] ki1;
    logic [15:0] ki2;
    logic [15:0] ki3;
  } subkey_t;

  localparam logic [15:0] KEY_CONST [8] = '{
    16'h0123, 16'h4567, 16'h89AB, 16'hCDEF, 16'hFEDC, 16'hBA98, 16'h7654, 16'h3210
  };

  localparam logic [6:0] S7 [128] = '{
    7'd54, 7'd50, 7'd62, 7'd56, 7'd22, 7'd34, 7'd94, 7'd96, 7'd38, 7'd6, 7'd63, 7'd93,
    7'd2, 7'd18, 7'd123, 7'd33,
    7'd55, 7'd113, 7'd39, 7'd114, 7'd21, 7'd67, 7'd65, 7'd12, 7'd47, 7'd73, 7'd46, 7'd27,
    7'd25, 7'd111, 7'd124, 7'd81,
    7'd53, 7'd9, 7'd121, 7'd79, 7'd52, 7'd60, 7'd58, 7'd48, 7'd101, 7'd127, 7'd40, 7'd120,
    7'd104, 7'd70, 7'd71, 7'd43,
    7'd20, 7'd122, 7'd72, 7'd61, 7'd23, 7'd109, 7'd13, 7'd100, 7'd77, 7'd1, 7'd16, 7'd7,
    7'd82, 7'd10, 7'd105, 7'd98,
    7'd117, 7'd116, 7'd76, 7'd11, 7'd89, 7'd106, 7'd0, 7'd125, 7'd118, 7'd99, 7'd86, 7'd69,
    7'd30, 7'd57, 7'd126, 7'd87,
    7'd112, 7'd51, 7'd17, 7'd5, 7'd95, 7'd14, 7'd90, 7'd84, 7'd91, 7'd8, 7'd35, 7'd103,
    7'd32, 7'd97, 7'd28, 7'd66,
    7'd102, 7'd31, 7'd26, 7'd45, 7'd75, 7'd4, 7'd85, 7'd92, 7'd37, 7'd74, 7'd80, 7'd49,
    7'd68, 7'd29, 7'd115, 7'd44,
    7'd64, 7'd107, 7'd108, 7'd24, 7'd110, 7'd83, 7'd36, 7'd78, 7'd42, 7'd19, 7'd15, 7'd41,
    7'd88, 7'd119, 7'd59, 7'd3
  };

  localparam logic [8:0] S9 [512] = '{
    9'd167, 9'd239, 9'd161, 9'd379, 9'd391, 9'd334, 9'd9, 9'd338, 9'd38, 9'd226, 9'd48,
    9'd358, 9'd452, 9'd385, 9'd90, 9'd397,
    9'd183, 9'd253, 9'd147, 9'd331, 9'd415, 9'd340, 9'd51, 9'd362, 9'd306, 9'd500, 9'd262,
    9'd82, 9'd216, 9'd159, 9'd356, 9'd177,
    9'd175, 9'd241, 9'd489, 9'd37, 9'd206, 9'd17, 9'd0, 9'd333, 9'd44, 9'd254, 9'd378,
    9'd58, 9'd143, 9'd220, 9'd81, 9'd400,
    9'd95, 9'd3, 9'd315, 9'd245, 9'd54, 9'd235, 9'd218, 9'd405, 9'd472, 9'd264, 9'd172,
    9'd494, 9'd371, 9'd290, 9'd399, 9'd76,
    9'd165, 9'd197, 9'd395, 9'd121, 9'd257, 9'd480, 9'd423, 9'd212, 9'd240, 9'd28, 9'd462,
    9'd176, 9'd406, 9'd507, 9'd288, 9'd223,
    9'd501, 9'd407, 9'd249, 9'd265, 9'd89, 9'd186, 9'd221, 9'd428, 9'd164, 9'd74, 9'd440,
    9'd196, 9'd458, 9'd421, 9'd350, 9'd163,
    9'd232, 9'd158, 9'd134, 9'd354, 9'd13, 9'd250, 9'd491, 9'd142, 9'd191, 9'd69, 9'd193,
    9'd425, 9'd152, 9'd227, 9'd366, 9'd135,
    9'd344, 9'd300, 9'd276, 9'd242, 9'd437, 9'd320, 9'd113, 9'd278, 9'd11, 9'd243, 9'd87,
    9'd317, 9'd36, 9'd93, 9'd496, 9'd27,
    9'd487, 9'd446, 9'd482, 9'd41, 9'd68, 9'd156, 9'd457, 9'd131, 9'd326, 9'd403, 9'd339,
    9'd20, 9'd39, 9'd115, 9'd442, 9'd124,
    9'd475, 9'd384, 9'd508, 9'd53, 9'd112, 9'd170, 9'd479, 9'd151, 9'd126, 9'd169, 9'd73,
    9'd268, 9'd279, 9'd321, 9'd168, 9'd364,
    9'd363, 9'd292, 9'd46, 9'd499, 9'd393, 9'd327, 9'd324, 9'd24, 9'd456, 9'd267, 9'd157,
    9'd460, 9'd488, 9'd426, 9'd309, 9'd229,
    9'd439, 9'd506, 9'd208, 9'd271, 9'd349, 9'd401, 9'd434, 9'd236, 9'd16, 9'd209, 9'd359,
    9'd52, 9'd56, 9'd120, 9'd199, 9'd277,
    9'd465, 9'd416, 9'd252, 9'd287, 9'd246, 9'd6, 9'd83, 9'd305, 9'd420, 9'd345, 9'd153,
    9'd502, 9'd65, 9'd61, 9'd244, 9'd282,
    9'd173, 9'd222, 9'd418, 9'd67, 9'd386, 9'd368, 9'd261, 9'd101, 9'd476, 9'd291, 9'd195,
    9'd430, 9'd49, 9'd79, 9'd166, 9'd330,
    9'd280, 9'd383, 9'd373, 9'd128, 9'd382, 9'd408, 9'd155, 9'd495, 9'd367, 9'd388, 9'd274,
    9'd107, 9'd459, 9'd417, 9'd62, 9'd454,
    9'd132, 9'd225, 9'd203, 9'd316, 9'd234, 9'd14, 9'd301, 9'd91, 9'd503, 9'd286, 9'd424,
    9'd211, 9'd347, 9'd307, 9'd140, 9'd374,
    9'd35, 9'd103, 9'd125, 9'd427, 9'd19, 9'd214, 9'd453, 9'd146, 9'd498, 9'd314, 9'd444,
    9'd230, 9'd256, 9'd329, 9'd198, 9'd285,
    9'd50, 9'd116, 9'd78, 9'd410, 9'd10, 9'd205, 9'd510, 9'd171, 9'd231, 9'd45, 9'd139,
    9'd467, 9'd29, 9'd86, 9'd505, 9'd32,
    9'd72, 9'd26, 9'd342, 9'd150, 9'd313, 9'd490, 9'd431, 9'd238, 9'd411, 9'd325, 9'd149,
    9'd473, 9'd40, 9'd119, 9'd174, 9'd355,
    9'd185, 9'd233, 9'd389, 9'd71, 9'd448, 9'd273, 9'd372, 9'd55, 9'd110, 9'd178, 9'd322,
    9'd12, 9'd469, 9'd392, 9'd369, 9'd190,
    9'd1, 9'd109, 9'd375, 9'd137, 9'd181, 9'd88, 9'd75, 9'd308, 9'd260, 9'd484, 9'd98,
    9'd272, 9'd370, 9'd275, 9'd412, 9'd111,
    9'd336, 9'd318, 9'd4, 9'd504, 9'd492, 9'd259, 9'd304, 9'd77, 9'd337, 9'd435, 9'd21,
    9'd357, 9'd303, 9'd332, 9'd483, 9'd18,
    9'd47, 9'd85, 9'd25, 9'd497, 9'd474, 9'd289, 9'd100, 9'd269, 9'd296, 9'd478, 9'd270,
    9'd106, 9'd31, 9'd104, 9'd433, 9'd84,
    9'd414, 9'd486, 9'd394, 9'd96, 9'd99, 9'd154, 9'd511, 9'd148, 9'd413, 9'd361, 9'd409,
    9'd255, 9'd162, 9'd215, 9'd302, 9'd201,
    9'd266, 9'd351, 9'd343, 9'd144, 9'd441, 9'd365, 9'd108, 9'd298, 9'd251, 9'd34, 9'd182,
    9'd509, 9'd138, 9'd210, 9'd335, 9'd133,
    9'd311, 9'd352, 9'd328, 9'd141, 9'd396, 9'd346, 9'd123, 9'd319, 9'd450, 9'd281, 9'd429,
    9'd228, 9'd443, 9'd481, 9'd92, 9'd404,
    9'd485, 9'd422, 9'd248, 9'd297, 9'd23, 9'd213, 9'd130, 9'd466, 9'd22, 9'd217, 9'd283,
    9'd70, 9'd294, 9'd360, 9'd419, 9'd127,
    9'd312, 9'd377, 9'd7, 9'd468, 9'd194, 9'd2, 9'd117, 9'd295, 9'd463, 9'd258, 9'd224,
    9'd447, 9'd247, 9'd187, 9'd80, 9'd398,
    9'd284, 9'd353, 9'd105, 9'd390, 9'd299, 9'd471, 9'd470, 9'd184, 9'd57, 9'd200, 9'd348,
    9'd63, 9'd204, 9'd188, 9'd33, 9'd451,
    9'd97, 9'd30, 9'd310, 9'd219, 9'd94, 9'd160, 9'd129, 9'd493, 9'd64, 9'd179, 9'd263,
    9'd102, 9'd189, 9'd207, 9'd114, 9'd402,
    9'd438, 9'd477, 9'd387, 9'd122, 9'd192, 9'd42, 9'd381, 9'd5, 9'd145, 9'd118, 9'd180,
    9'd449, 9'd293, 9'd323, 9'd136, 9'd380,
    9'd43, 9'd66, 9'd60, 9'd455, 9'd341, 9'd445, 9'd202, 9'd432, 9'd8, 9'd237, 9'd15,
    9'd376, 9'd436, 9'd464, 9'd59, 9'd461
  };

  function automatic logic [15:0] rotl(input logic [15:0] v, input int amt);
    logic [31:0] d;
    begin
      d = {v, v} << amt;
      return d[31:16];
    end
  endfunction

  // subkeys of round rnd (0..7) from the 128-bit key
  function automatic subkey_t round_keys(input logic [63:0] khi, input logic [63:0] klo,
                                         input logic [2:0] rnd);
    logic [15:0] kw [8];
    logic [15:0] kp [8];
    subkey_t     sk;
    begin
      for (int i = 0; i < 4; i++) begin
        kw[i]     = khi[63 - 16 * i -: 16];
        kw[i + 4] = klo[63 - 16 * i -: 16];
      end
      for (int i = 0; i < 8; i++) begin
        kp[i] = kw[i] ^ KEY_CONST[i];
      end
      sk.kl1 = rotl(kw[rnd], 1);
      sk.kl2 = kp[3'(rnd + 3'd2)];
      sk.ko1 = rotl(kw[3'(rnd + 3'd1)], 5);
      sk.ko2 = rotl(kw[3'(rnd + 3'd5)], 8);
      sk.ko3 = rotl(kw[3'(rnd + 3'd6)], 13);
      sk.ki1 = kp[3'(rnd + 3'd4)];
      sk.ki2 = kp[3'(rnd + 3'd3)];
      sk.ki3 = kp[3'(rnd + 3'd7)];
      return sk;
    end
  endfunction

  function automatic logic [15:0] fi(input logic [15:0] x, input logic [15:0] sub);
    logic [8:0] nine;
    logic [6:0] seven;
    begin
      nine  = S9[x[15:7]] ^ {2'b00, x[6:0]};
      seven = S7[x[6:0]] ^ nine[6:0];
      seven = seven ^ sub[15:9];
      nine  = nine ^ sub[8:0];
      nine  = S9[nine] ^ {2'b00, seven};
      seven = S7[seven] ^ nine[6:0];
      return {seven, nine};
    end
  endfunction

  function automatic logic [31:0] fl(input logic [31:0] x, input subkey_t sk);
    logic [15:0] hi;
    logic [15:0] lo;
    begin
      hi = x[31:16];
      lo = x[15:0] ^ rotl(x[31:16] & sk.kl1, 1);
      hi = hi ^ rotl(lo | sk.kl2, 1);
      return {hi, lo};
    end
  endfunction

endpackage

/* design/kasumi_round.sv */
// One round cell of the KASUMI pipeline: FL and FO over three registered stages.
// Depends on kasumi_pkg.
module kasumi_round #(
  parameter int POS = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         key_high,
  input  logic [63:0]         key_low,
  input  kasumi_pkg::blk_t    din,
  output kasumi_pkg::blk_t    dout
);

  localparam logic [2:0] ENC_RND = 3'(POS);
  localparam logic [2:0] DEC_RND = 3'(7 - POS);

  kasumi_pkg::blk_t   s1;
  kasumi_pkg::blk_t   s2;
  logic [15:0]        a1_s1, b_s1;
  logic [15:0]        a1_s2, b1_s2;

  kasumi_pkg::subkey_t sk0, sk1, sk2;
  logic [2:0]          r0, r1, r2;
  logic [31:0]         t0, fo2, fout2;
  logic [15:0]         a1_c, b1_c, a2_c;

  assign r0 = din.kind ? DEC_RND : ENC_RND;
  assign r1 = s1.kind ? DEC_RND : ENC_RND;
  assign r2 = s2.kind ? DEC_RND : ENC_RND;
  assign sk0 = kasumi_pkg::round_keys(key_high, key_low, r0);
  assign sk1 = kasumi_pkg::round_keys(key_high, key_low, r1);
  assign sk2 = kasumi_pkg::round_keys(key_high, key_low, r2);

  // even rounds apply FL before FO, odd rounds after
  assign t0    = r0[0] ? din.x : kasumi_pkg::fl(din.x, sk0);
  assign a1_c  = kasumi_pkg::fi(t0[31:16] ^ sk0.ko1, sk0.ki1) ^ t0[15:0];
  assign b1_c  = kasumi_pkg::fi(b_s1 ^ sk1.ko2, sk1.ki2) ^ a1_s1;
  assign a2_c  = kasumi_pkg::fi(a1_s2 ^ sk2.ko3, sk2.ki3) ^ b1_s2;
  assign fo2   = {b1_s2, a2_c};
  assign fout2 = r2[0] ? kasumi_pkg::fl(fo2, sk2) : fo2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid   <= 1'b0;
      s2.valid   <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      s1.valid   <= din.valid;
      s2.valid   <= s1.valid;
      dout.valid <= s2.valid;
    end
    s1.kind <= din.kind;
    s1.x    <= din.x;
    s1.y    <= din.y;
    a1_s1   <= a1_c;
    b_s1    <= t0[15:0];
    s2.kind <= s1.kind;
    s2.x    <= s1.x;
    s2.y    <= s1.y;
    a1_s2   <= a1_s1;
    b1_s2   <= b1_c;
    // mix into the far half, then swap halves for the next cell
    dout.kind <= s2.kind;
    dout.x    <= s2.y ^ fout2;
    dout.y    <= s2.x;
  end

endmodule

/* design/kasumi_block_cipher.sv */
// Top level of the KASUMI block cipher: APB key registers and a chain of eight round cells.
// Depends on kasumi_pkg and kasumi_round.
//
//   channel   ports                                  direction  handshake
//   request   start, busy, kind, block_in            in         start && !busy
//   result    done, block_out                        out        done, one cycle
//   config    psel penable pwrite paddr pwdata ...   in/out     APB, pready tied high
//
// A request is taken every cycle outside reset; busy is high only while rst is high.
// Each result passes through eight round cells of three stages
// each, one FI evaluation per stage.
// Reset clears the valid bits of every stage and both key registers.
// The receiver cannot stall: done is a one-cycle strobe. Write keys only while idle.
module kasumi_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [63:0] block_in,
  output logic        done,
  output logic [63:0] block_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  kasumi_pkg::blk_t chain [kasumi_pkg::ROUNDS + 1];
  kasumi_pkg::blk_t last;

  // refuse requests while in reset, since the stage valid bits are held clear then
  assign busy   = rst;
  assign pready = 1'b1;

  // key registers: 8-byte stride, low address bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        kasumi_pkg::REG_KEY_HIGH: key_high <= pwdata;
        kasumi_pkg::REG_KEY_LOW:  key_low  <= pwdata;
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[3] == kasumi_pkg::REG_KEY_LOW) ? key_low : key_high;

  // decrypt enters with halves swapped, so every cell mixes x into y
  assign chain[0].valid = start && !busy;
  assign chain[0].kind  = kind;
  assign chain[0].x     = kind ? block_in[31:0] : block_in[63:32];
  assign chain[0].y     = kind ? block_in[63:32] : block_in[31:0];

  for (genvar g = 0; g < kasumi_pkg::ROUNDS; g++) begin : g_cell
    kasumi_round #(.POS(g)) u_round (
      .clk      (clk),
      .rst      (rst),
      .key_high (key_high),
      .key_low  (key_low),
      .din      (chain[g]),
      .dout     (chain[g + 1])
    );
  end

  assign last      = chain[kasumi_pkg::ROUNDS];
  assign done      = last.valid;
  assign block_out = last.kind ? {last.y, last.x} : {last.x, last.y};

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(kasumi_pkg::LATENCY) done)
    else $error("request did not complete on time");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, kasumi_pkg::LATENCY))
    else $error("result without matching request");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy && pready)
    else $error("request refused");

endmodule
